// File: rtl/thermostat_with_sensor_compensation_defines.svh
// Assertion macros shared by the thermostat RTL.
`ifndef THERMOSTAT_WITH_SENSOR_COMPENSATION_DEFINES_SVH
`define THERMOSTAT_WITH_SENSOR_COMPENSATION_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tsc_pkg.sv
// Package with types, widths and constants of the thermostat block.
package tsc_pkg;

  // Field widths
  localparam int SP_W     = 7;
  localparam int TEMP_W   = 16;
  localparam int CAL_W    = 16;
  localparam int TICK_W   = 8;
  localparam int RAW_W    = 20;
  localparam int CFG_IDX_W = 3;

  // Reset values of the setpoint and the tunable registers
  localparam logic [SP_W-1:0]   SETPOINT_RST      = 7'd20;
  localparam logic [SP_W-1:0]   SETPOINT_MAX_RST  = 7'd30;
  localparam logic [SP_W-1:0]   SETPOINT_MIN_RST  = 7'd15;
  localparam logic [TICK_W-1:0] BLINK_TICKS_RST   = 8'd10;
  localparam logic [TICK_W-1:0] LOCKOUT_TICKS_RST = 8'd1;

  // Serial multiplier geometry
  localparam int MA_W    = 22;            // multiplicand, signed
  localparam int MB_W    = 17;            // multiplier, signed, one bit per cycle
  localparam int ACC_W   = MA_W + 2;      // running high part
  localparam int PROD_W  = ACC_W + MB_W;
  localparam int MCNT_W  = $clog2(MB_W);

  // Compensation arithmetic
  localparam int X1_W        = 18;
  localparam int D_W         = 17;
  localparam int V1_SHIFT    = 11;
  localparam int V2_SHIFT    = 14;
  localparam int DD_SHIFT    = 12;
  localparam int SCALE_SHIFT = 8;
  localparam int V1_W        = 23;
  localparam int V2_W        = 23;
  localparam int DD_W        = 21;
  localparam int FINE_W      = 24;
  localparam int F5_W        = 27;
  localparam int TSCALE_W    = F5_W - SCALE_SHIFT;
  localparam int ROUND_BIAS  = 128;
  localparam int SP100_W     = 14;
  localparam int CENTI_PER_DEG = 100;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_T1        = 3'd0,
    CFG_CAL_T2        = 3'd1,
    CFG_CAL_T3        = 3'd2,
    CFG_SETPOINT_MAX  = 3'd3,
    CFG_SETPOINT_MIN  = 3'd4,
    CFG_BLINK_TICKS   = 3'd5,
    CFG_LOCKOUT_TICKS = 3'd6,
    CFG_SPARE         = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COMP,
    ST_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL1_GO,
    CS_MUL1,
    CS_MUL2,
    CS_MUL3,
    CS_SUM,
    CS_SCALE,
    CS_HEAT
  } cmp_state_t;

  // Command from the sequencer to the button unit
  typedef struct packed {
    logic tick;
    logic sample;
    logic plus_level;
    logic minus_level;
  } btn_cmd_t;

  // Status of the compensation unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: rtl/tsc_serial_mult.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
module tsc_serial_mult
  import tsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MA_W-1:0]   mcand,
  input  logic signed [MB_W-1:0]   mplier,
  output logic                     done,
  output logic signed [PROD_W-1:0] product
);

  logic                    busy;
  logic [MCNT_W-1:0]       count;
  logic signed [MA_W-1:0]  a_reg;
  logic signed [ACC_W-1:0] acc;
  logic [MB_W-1:0]         lo;
  logic                    last_bit;
  logic signed [ACC_W-1:0] partial;
  logic signed [ACC_W-1:0] sum;

  assign last_bit = (count == MCNT_W'(MB_W - 1));
  assign partial  = lo[0] ? ACC_W'(a_reg) : '0;
  // Top multiplier bit carries negative weight
  assign sum      = last_bit ? (acc - partial) : (acc + partial);
  assign product  = {acc, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (last_bit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= mcand;
      acc   <= '0;
      lo    <= mplier;
    end else if (busy) begin
      acc <= {sum[ACC_W-1], sum[ACC_W-1:1]};
      lo  <= {sum[0], lo[MB_W-1:1]};
    end
  end

endmodule

// File: rtl/tsc_compensate.sv
// Temperature compensation sequencer around the serial multiplier.
module tsc_compensate
  import tsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [RAW_W-1:0]         raw,
  input  logic [CAL_W-1:0]         cal_t1,
  input  logic signed [CAL_W-1:0]  cal_t2,
  input  logic signed [CAL_W-1:0]  cal_t3,
  input  logic [SP_W-1:0]          setpoint,
  output unit_stat_t               stat,
  output logic signed [TEMP_W-1:0] temperature,
  output logic                     heater
);

  cmp_state_t state, state_next;

  logic signed [X1_W-1:0]     x1;
  logic signed [D_W-1:0]      d;
  logic signed [V1_W-1:0]     v1;
  logic signed [V2_W-1:0]     v2;
  logic signed [FINE_W-1:0]   fine;
  logic                       mul_start;
  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic                       mul_done;
  logic signed [PROD_W-1:0]   product;
  logic signed [F5_W-1:0]     f5;
  logic signed [TSCALE_W-1:0] t_scaled;
  logic signed [TEMP_W-1:0]   t_sat;
  logic [SP100_W-1:0]         sp100;

  tsc_serial_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (product)
  );

  // fine * 5 + rounding, then drop eight bits and clamp to 16 bits
  assign f5       = (F5_W'(fine) <<< 2) + F5_W'(fine) + F5_W'(ROUND_BIAS);
  assign t_scaled = f5[F5_W-1:SCALE_SHIFT];
  always_comb begin
    if (!t_scaled[TSCALE_W-1] && (t_scaled[TSCALE_W-2:TEMP_W-1] != '0)) begin
      t_sat = {1'b0, {(TEMP_W-1){1'b1}}};
    end else if (t_scaled[TSCALE_W-1] && (t_scaled[TSCALE_W-2:TEMP_W-1] != '1)) begin
      t_sat = {1'b1, {(TEMP_W-1){1'b0}}};
    end else begin
      t_sat = t_scaled[TEMP_W-1:0];
    end
  end

  assign sp100 = SP100_W'(setpoint) * SP100_W'(CENTI_PER_DEG);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = MA_W'(x1);
    mul_b      = MB_W'(cal_t2);
    stat.busy  = (state != CS_IDLE);
    stat.done  = 1'b0;
    unique case (state)
      CS_IDLE: begin
        if (start) begin
          state_next = CS_MUL1_GO;
        end
      end
      CS_MUL1_GO: begin
        mul_start  = 1'b1;
        state_next = CS_MUL1;
      end
      CS_MUL1: begin
        mul_a = MA_W'(d);
        mul_b = d;
        if (mul_done) begin
          mul_start  = 1'b1;
          state_next = CS_MUL2;
        end
      end
      CS_MUL2: begin
        mul_a = MA_W'({1'b0, product[DD_SHIFT+DD_W-1:DD_SHIFT]});
        mul_b = MB_W'(cal_t3);
        if (mul_done) begin
          mul_start  = 1'b1;
          state_next = CS_MUL3;
        end
      end
      CS_MUL3: begin
        if (mul_done) begin
          state_next = CS_SUM;
        end
      end
      CS_SUM: begin
        state_next = CS_SCALE;
      end
      CS_SCALE: begin
        state_next = CS_HEAT;
      end
      CS_HEAT: begin
        stat.done  = 1'b1;
        state_next = CS_IDLE;
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == CS_IDLE && start) begin
      x1 <= $signed({1'b0, raw[RAW_W-1:3]}) - $signed({1'b0, cal_t1, 1'b0});
      d  <= $signed({1'b0, raw[RAW_W-1:4]}) - $signed({1'b0, cal_t1});
    end
    if (state == CS_MUL1 && mul_done) begin
      v1 <= product[V1_SHIFT+V1_W-1:V1_SHIFT];
    end
    if (state == CS_MUL3 && mul_done) begin
      v2 <= product[V2_SHIFT+V2_W-1:V2_SHIFT];
    end
    if (state == CS_SUM) begin
      fine <= FINE_W'(v1) + FINE_W'(v2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature <= '0;
      heater      <= 1'b0;
    end else begin
      if (state == CS_SCALE) begin
        temperature <= t_sat;
      end
      if (state == CS_HEAT) begin
        heater <= !(temperature > $signed({{(TEMP_W-SP100_W){1'b0}}, sp100}));
      end
    end
  end

endmodule

// File: rtl/tsc_buttons.sv
// Button edge handling, lockout and blink timers, and the setpoint.
module tsc_buttons
  import tsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  btn_cmd_t          cmd,
  input  logic [SP_W-1:0]   setpoint_max,
  input  logic [SP_W-1:0]   setpoint_min,
  input  logic [TICK_W-1:0] blink_ticks,
  input  logic [TICK_W-1:0] lockout_ticks,
  output logic [SP_W-1:0]   setpoint,
  output logic              red_led,
  output logic              blue_led
);

  typedef struct packed {
    logic              held;
    logic              blinking;
    logic [TICK_W-1:0] wait_cnt;
  } btn_state_t;

  btn_state_t plus_st, minus_st, plus_next, minus_next;
  logic [SP_W-1:0] sp_mid, setpoint_next;
  logic plus_at_limit, minus_at_limit;
  logic plus_step, minus_step;

  function automatic logic is_free(btn_state_t s);
    return !s.blinking && (s.wait_cnt == '0);
  endfunction

  function automatic btn_state_t tick_one(btn_state_t s, logic [TICK_W-1:0] lockout);
    btn_state_t r;
    r = s;
    if (s.blinking) begin
      if (s.wait_cnt <= TICK_W'(1)) begin
        r.blinking = 1'b0;
        r.wait_cnt = lockout;
      end else begin
        r.wait_cnt = s.wait_cnt - 1'b1;
      end
    end else if (s.wait_cnt != '0) begin
      r.wait_cnt = s.wait_cnt - 1'b1;
    end
    return r;
  endfunction

  function automatic btn_state_t press_one(btn_state_t s, logic level, logic at_limit,
                                          logic [TICK_W-1:0] blink,
                                          logic [TICK_W-1:0] lockout);
    btn_state_t r;
    r = s;
    if (is_free(s)) begin
      if (!s.held && level) begin
        r.held = 1'b1;
        if (at_limit) begin
          r.blinking = 1'b1;
          r.wait_cnt = blink;
        end else begin
          r.wait_cnt = lockout;
        end
      end else if (s.held && !level) begin
        r.held = 1'b0;
      end
    end
    return r;
  endfunction

  // Plus goes first; minus sees the setpoint that plus left
  always_comb begin
    plus_at_limit  = !(setpoint < setpoint_max);
    plus_step      = cmd.sample && is_free(plus_st) && !plus_st.held && cmd.plus_level
                     && !plus_at_limit;
    sp_mid         = setpoint + SP_W'(plus_step);
    minus_at_limit = !(sp_mid > setpoint_min);
    minus_step     = cmd.sample && is_free(minus_st) && !minus_st.held && cmd.minus_level
                     && !minus_at_limit;
    setpoint_next  = sp_mid - SP_W'(minus_step);

    plus_next  = plus_st;
    minus_next = minus_st;
    if (cmd.tick) begin
      plus_next  = tick_one(plus_st, lockout_ticks);
      minus_next = tick_one(minus_st, lockout_ticks);
    end else if (cmd.sample) begin
      plus_next  = press_one(plus_st, cmd.plus_level, plus_at_limit, blink_ticks,
                             lockout_ticks);
      minus_next = press_one(minus_st, cmd.minus_level, minus_at_limit, blink_ticks,
                             lockout_ticks);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= SETPOINT_RST;
      plus_st  <= '0;
      minus_st <= '0;
    end else begin
      setpoint <= setpoint_next;
      plus_st  <= plus_next;
      minus_st <= minus_next;
    end
  end

  assign red_led  = plus_st.blinking;
  assign blue_led = minus_st.blinking;

endmodule

// File: rtl/thermostat_with_sensor_compensation.sv
// Top level of the on-off thermostat with sensor temperature compensation.
//
//  Channel   | Direction | Transfer condition           | Contents
//  ----------+-----------+------------------------------+------------------------------
//  s_axis_*  | in        | s_axis_tvalid & s_axis_tready | opcode in tuser, button
//            |           |                              | levels and raw bytes in tdata
//  m_axis_*  | out       | m_axis_tvalid & m_axis_tready | setpoint, temperature,
//            |           |                              | heater and LEDs in tdata
//  cfg_*     | in        | cfg_we                       | register index and value
//
// Sequence: a tick, a button sample or an unused opcode is taken, executed, and its
// result loaded into the output register. A temperature sample instead runs three
// 17-step passes through the bit-serial multiplier before its result is loaded.
// Reset: rst is synchronous; setpoint to 20 degrees, timers, temperature, limits and
// tick counts to their defaults. Stalls: the result waits in the output register; the
// next item is taken meanwhile, and its result is held back until the register frees.
`include "thermostat_with_sensor_compensation_defines.svh"

module thermostat_with_sensor_compensation
  import tsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [0] plus_pressed, [1] minus_pressed, [9:2] raw_msb, [17:10] raw_lsb,
  // [25:18] raw_xlsb, [31:26] zero
  input  logic [31:0]           s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]            s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [6:0] setpoint_now, [22:7] temperature_centi, [23] heater_on,
  // [24] red_led, [25] blue_led, [31:26] zero
  output logic [31:0]           m_axis_tdata,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CAL_W-1:0]      cfg_data
);

  // Configuration registers
  logic [CAL_W-1:0]        cal_t1;
  logic signed [CAL_W-1:0] cal_t2;
  logic signed [CAL_W-1:0] cal_t3;
  logic [SP_W-1:0]         setpoint_max;
  logic [SP_W-1:0]         setpoint_min;
  logic [TICK_W-1:0]       blink_ticks;
  logic [TICK_W-1:0]       lockout_ticks;

  // Captured input item
  op_t              item_op;
  logic             item_plus;
  logic             item_minus;
  logic [RAW_W-1:0] item_raw;

  top_state_t state, state_next;
  btn_cmd_t   btn_cmd;
  logic       comp_start;
  logic       out_load;
  unit_stat_t comp_stat;

  logic [SP_W-1:0]          setpoint;
  logic signed [TEMP_W-1:0] temperature;
  logic                     heater;
  logic                     red_led;
  logic                     blue_led;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_t1        <= '0;
      cal_t2        <= '0;
      cal_t3        <= '0;
      setpoint_max  <= SETPOINT_MAX_RST;
      setpoint_min  <= SETPOINT_MIN_RST;
      blink_ticks   <= BLINK_TICKS_RST;
      lockout_ticks <= LOCKOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAL_T1:        cal_t1        <= cfg_data;
        CFG_CAL_T2:        cal_t2        <= cfg_data;
        CFG_CAL_T3:        cal_t3        <= cfg_data;
        CFG_SETPOINT_MAX:  setpoint_max  <= cfg_data[SP_W-1:0];
        CFG_SETPOINT_MIN:  setpoint_min  <= cfg_data[SP_W-1:0];
        CFG_BLINK_TICKS:   blink_ticks   <= cfg_data[TICK_W-1:0];
        CFG_LOCKOUT_TICKS: lockout_ticks <= cfg_data[TICK_W-1:0];
        CFG_SPARE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted item while it is worked on
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_op    <= op_t'(s_axis_tuser);
      item_plus  <= s_axis_tdata[0];
      item_minus <= s_axis_tdata[1];
      item_raw   <= {s_axis_tdata[9:2], s_axis_tdata[17:10], s_axis_tdata[25:22]};
    end
  end

  tsc_buttons u_buttons (
    .clk           (clk),
    .rst           (rst),
    .cmd           (btn_cmd),
    .setpoint_max  (setpoint_max),
    .setpoint_min  (setpoint_min),
    .blink_ticks   (blink_ticks),
    .lockout_ticks (lockout_ticks),
    .setpoint      (setpoint),
    .red_led       (red_led),
    .blue_led      (blue_led)
  );

  tsc_compensate u_comp (
    .clk         (clk),
    .rst         (rst),
    .start       (comp_start),
    .raw         (item_raw),
    .cal_t1      (cal_t1),
    .cal_t2      (cal_t2),
    .cal_t3      (cal_t3),
    .setpoint    (setpoint),
    .stat        (comp_stat),
    .temperature (temperature),
    .heater      (heater)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: take one item, dispatch it, then load its result
  always_comb begin
    state_next          = state;
    s_axis_tready       = 1'b0;
    btn_cmd.tick        = 1'b0;
    btn_cmd.sample      = 1'b0;
    btn_cmd.plus_level  = item_plus;
    btn_cmd.minus_level = item_minus;
    comp_start          = 1'b0;
    out_load            = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (item_op)
          OP_TICK: begin
            btn_cmd.tick = 1'b1;
            state_next   = ST_EMIT;
          end
          OP_BUTTON: begin
            btn_cmd.sample = 1'b1;
            state_next     = ST_EMIT;
          end
          OP_SAMPLE: begin
            comp_start = 1'b1;
            state_next = ST_COMP;
          end
          OP_NOP: begin
            state_next = ST_EMIT;
          end
          default: begin
            state_next = ST_EMIT;
          end
        endcase
      end
      ST_COMP: begin
        if (comp_stat.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Wait for the output register to drain
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: parts the result from the input side
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'd0, blue_led, red_led, heater, temperature, setpoint};
    end
  end

  // One item in flight at a time
  `TSC_ASSERT_NEXT(a_one_in_flight, clk, rst, in_xfer, !s_axis_tready, "item taken while busy")
  // Compensation runs only while the sequencer waits on it
  `TSC_ASSERT_SAME(a_comp_busy, clk, rst, comp_stat.busy, state == ST_COMP, "stray compensation")
  `TSC_ASSERT_SAME(a_comp_done, clk, rst, comp_stat.done, state == ST_COMP, "unexpected done")
  // A new result appears only after the emit step
  `TSC_ASSERT_SAME(a_load_src, clk, rst, $rose(m_axis_tvalid), $past(state) == ST_EMIT, "bad load")

endmodule

// File: bench/thermostat_with_sensor_compensation_tb.sv
// Self-checking testbench of the thermostat: stream stimulus, status scoreboard, config phases.
module thermostat_with_sensor_compensation_tb
  import tsc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_TICKS = 9;
  localparam int CYCLE_LIMIT = 400000;  // several times the slowest legal run
  localparam int TAIL_CYCLES = 100;     // outlasts a temperature sample
  localparam int LONG_HOLD   = 400;     // receiver stall that backs the block up
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 140;
  localparam int PLUS_BTN    = 0;
  localparam int MINUS_BTN   = 1;

  // One input item as the block sees it
  typedef struct {
    op_t        op;
    bit         plus;
    bit         minus;
    logic [7:0] msb;
    logic [7:0] lsb;
    logic [7:0] xlsb;
  } thermo_cmd_t;

  // One status transfer on the output stream
  typedef struct {
    logic [SP_W-1:0]          setpoint;
    logic signed [TEMP_W-1:0] temp;
    bit                       heater;
    bit                       red;
    bit                       blue;
  } status_t;

  // Values for the seven registers, in register order
  typedef struct {
    int t1;
    int t2;
    int t3;
    int sp_max;
    int sp_min;
    int blink;
    int lock;
  } settings_t;

  // Mirror of the thermostat: register copies, button and temperature state,
  // and the queue of status transfers still owed by the block.
  class thermostat_scoreboard;
    int      t1;
    shortint t2;
    shortint t3;
    int      sp_max;
    int      sp_min;
    int      blink_len;
    int      lock_len;

    int      setpoint;
    shortint temp_centi;
    bit      heater;
    bit      held[2];
    bit      blinking[2];
    int      lock_cnt[2];

    status_t pending[$];

    int errors;
    int checked;
    int op_count[4];
    int limit_presses;
    int saturated;
    int heater_on_samples;

    function new();
      t1 = 0;
      t2 = 0;
      t3 = 0;
      sp_max = int'(SETPOINT_MAX_RST);
      sp_min = int'(SETPOINT_MIN_RST);
      blink_len = int'(BLINK_TICKS_RST);
      lock_len = int'(LOCKOUT_TICKS_RST);
      setpoint = int'(SETPOINT_RST);
      temp_centi = 0;
      heater = 1'b0;
      held = '{1'b0, 1'b0};
      blinking = '{1'b0, 1'b0};
      lock_cnt = '{0, 0};
      errors = 0;
      checked = 0;
      op_count = '{0, 0, 0, 0};
      limit_presses = 0;
      saturated = 0;
      heater_on_samples = 0;
    endfunction

    function void write_register(cfg_idx_t idx, logic [CAL_W-1:0] value);
      case (idx)
        CFG_CAL_T1:        t1 = int'(value);
        CFG_CAL_T2:        t2 = shortint'(value);
        CFG_CAL_T3:        t3 = shortint'(value);
        CFG_SETPOINT_MAX:  sp_max = int'(value[SP_W-1:0]);
        CFG_SETPOINT_MIN:  sp_min = int'(value[SP_W-1:0]);
        CFG_BLINK_TICKS:   blink_len = int'(value[TICK_W-1:0]);
        CFG_LOCKOUT_TICKS: lock_len = int'(value[TICK_W-1:0]);
        default: ;
      endcase
    endfunction

    function bit idle();
      return pending.size() == 0;
    endfunction

    // A blinking button counts down to the end of the blink, then starts its
    // lockout; a locked button just counts down to zero.
    function void tick_button(int b);
      if (blinking[b]) begin
        if (lock_cnt[b] <= 1) begin
          blinking[b] = 1'b0;
          lock_cnt[b] = lock_len;
        end else begin
          lock_cnt[b]--;
        end
      end else if (lock_cnt[b] != 0) begin
        lock_cnt[b]--;
      end
    endfunction

    // Rising edge of a free button steps the setpoint, or lights its LED when
    // the setpoint is at or beyond the limit.
    function void poll_button(int b, bit level);
      bit at_limit;
      if (blinking[b] || lock_cnt[b] != 0) return;
      if (!held[b] && level) begin
        if (b == PLUS_BTN) begin
          at_limit = !(setpoint < sp_max);
          if (!at_limit) setpoint++;
        end else begin
          at_limit = !(setpoint > sp_min);
          if (!at_limit) setpoint--;
        end
        held[b] = 1'b1;
        if (at_limit) begin
          blinking[b] = 1'b1;
          lock_cnt[b] = blink_len;
          limit_presses++;
        end else begin
          lock_cnt[b] = lock_len;
        end
      end else if (held[b] && !level) begin
        held[b] = 1'b0;
      end
    endfunction

    // Integer compensation, carried out in 64 bits so nothing wraps; >>> on a
    // signed value floors, which is what the formula wants.
    function shortint compensate_raw(logic [RAW_W-1:0] adc);
      longint a;
      longint c1;
      longint v1;
      longint d;
      longint v2;
      longint fine;
      longint t;
      a = longint'(adc);
      c1 = t1;
      v1 = (((a >>> 3) - c1 * 2) * longint'(t2)) >>> 11;
      d = (a >>> 4) - c1;
      v2 = (((d * d) >>> 12) * longint'(t3)) >>> 14;
      fine = v1 + v2;
      t = (fine * 5 + 128) >>> 8;
      if (t > 32767 || t < -32768) saturated++;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return shortint'(t);
    endfunction

    function void note_command(thermo_cmd_t c);
      status_t s;
      op_count[int'(c.op)]++;
      case (c.op)
        OP_TICK: begin
          tick_button(PLUS_BTN);
          tick_button(MINUS_BTN);
        end
        OP_BUTTON: begin
          // plus is handled before minus when both arrive together
          poll_button(PLUS_BTN, c.plus);
          poll_button(MINUS_BTN, c.minus);
        end
        OP_SAMPLE: begin
          temp_centi = compensate_raw({c.msb, c.lsb, c.xlsb[7:4]});
          heater = !(int'(temp_centi) > setpoint * 100);
          if (heater) heater_on_samples++;
        end
        default: ;
      endcase
      s.setpoint = SP_W'(setpoint);
      s.temp = temp_centi;
      s.heater = heater;
      s.red = blinking[PLUS_BTN];
      s.blue = blinking[MINUS_BTN];
      pending.push_back(s);
    endfunction

    function void check_status(logic [31:0] data);
      status_t s;
      if (pending.size() == 0) begin
        $error("status transfer %h arrived with nothing expected", data);
        errors++;
        return;
      end
      s = pending.pop_front();
      checked++;
      if (data[6:0] !== s.setpoint) begin
        $error("setpoint_now: expected %0d, actual %0d", s.setpoint, data[6:0]);
        errors++;
      end
      if (data[22:7] !== s.temp) begin
        $error("temperature_centi: expected %0d, actual %0d", s.temp, $signed(data[22:7]));
        errors++;
      end
      if (data[23] !== s.heater) begin
        $error("heater_on: expected %0b, actual %0b", s.heater, data[23]);
        errors++;
      end
      if (data[24] !== s.red) begin
        $error("red_led: expected %0b, actual %0b", s.red, data[24]);
        errors++;
      end
      if (data[25] !== s.blue) begin
        $error("blue_led: expected %0b, actual %0b", s.blue, data[25]);
        errors++;
      end
      if (data[31:26] !== 6'd0) begin
        $error("padding: expected 0, actual %0h", data[31:26]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0]     cfg_data = '0;

  thermostat_scoreboard thermo_sb = new();

  int cycle_count = 0;
  bit long_hold_req = 1'b0;   // raised by the stimulus, taken by the receiver
  bit hold_active = 1'b0;
  int long_holds = 0;
  bit cal_realistic = 1'b0;   // calibration near a real sensor: aim raw values at room range

  thermostat_with_sensor_compensation dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: any hang ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d status transfers outstanding", cycle_count,
             thermo_sb.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output monitor: values read here are the ones present before the edge,
  // so a transfer is seen exactly when the block counts it.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      thermo_sb.check_status(m_axis_tdata);
    end
  end

  // Receiver: switch between stall patterns after spans of random length. When the
  // stimulus asks for it, hold tready low for a long stretch so the block's
  // output register and input stage both fill up.
  initial begin : receiver
    int mode;
    int span;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_active = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
        long_holds++;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      for (int k = 0; k < span && !long_hold_req; k++) begin
        case (mode)
          0: m_axis_tready <= 1'b1;                          // always ready
          1: m_axis_tready <= 1'($urandom_range(0, 1));      // coin flip
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
          default: m_axis_tready <= ((k % 8) < 5);           // fixed duty cycle
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic thermo_cmd_t make_cmd(op_t op, bit plus, bit minus,
                                           logic [7:0] msb, logic [7:0] lsb,
                                           logic [7:0] xlsb);
    thermo_cmd_t c;
    c.op = op;
    c.plus = plus;
    c.minus = minus;
    c.msb = msb;
    c.lsb = lsb;
    c.xlsb = xlsb;
    return c;
  endfunction

  // Mostly ticks and button polls, a fair share of temperature samples and a
  // few unused opcodes. Samples land near room temperature when the
  // calibration is realistic, so the heater decision flips often.
  function automatic thermo_cmd_t random_cmd();
    thermo_cmd_t c;
    int pick;
    logic [RAW_W-1:0] adc;
    pick = $urandom_range(0, 99);
    if (pick < 35) c.op = OP_TICK;
    else if (pick < 70) c.op = OP_BUTTON;
    else if (pick < 95) c.op = OP_SAMPLE;
    else c.op = OP_NOP;
    c.plus = 1'($urandom_range(0, 1));
    c.minus = 1'($urandom_range(0, 1));
    c.msb = 8'($urandom);
    c.lsb = 8'($urandom);
    c.xlsb = 8'($urandom);
    if (c.op == OP_SAMPLE) begin
      pick = $urandom_range(0, 9);
      if (pick < 7 && cal_realistic) adc = RAW_W'($urandom_range(470000, 570000));
      else if (pick == 9) adc = $urandom_range(0, 1) ? {RAW_W{1'b1}} : '0;
      else adc = RAW_W'($urandom);
      c.msb = adc[19:12];
      c.lsb = adc[11:4];
      c.xlsb = {adc[3:0], c.xlsb[3:0]};   // low nibble is ignored by the block
    end
    return c;
  endfunction

  function automatic int random_cal_word();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 32767 : -32768;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    int pick;
    cal_realistic = ($urandom_range(0, 9) < 7);
    if (cal_realistic) begin
      s.t1 = $urandom_range(26000, 29000);
      s.t2 = $urandom_range(25000, 27500);
      s.t3 = -int'($urandom_range(500, 1500));
    end else begin
      s.t1 = ($urandom_range(0, 3) == 0) ? 65535 * $urandom_range(0, 1)
                                         : $urandom_range(0, 65535);
      s.t2 = random_cal_word();
      s.t3 = random_cal_word();
    end
    pick = $urandom_range(0, 5);
    case (pick)
      0: begin                                // widest limits
        s.sp_min = 0;
        s.sp_max = 127;
      end
      1: begin                                // single allowed value
        s.sp_min = $urandom_range(15, 30);
        s.sp_max = s.sp_min;
      end
      2: begin                                // crossed limits
        s.sp_min = $urandom_range(26, 40);
        s.sp_max = $urandom_range(10, 25);
      end
      default: begin
        s.sp_min = $urandom_range(10, 22);
        s.sp_max = $urandom_range(22, 35);
      end
    endcase
    pick = $urandom_range(0, 5);
    s.blink = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(1, 6);
    pick = $urandom_range(0, 5);
    s.lock = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(1, 4);
    return s;
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_cmd(input thermo_cmd_t c);
    s_axis_tuser <= c.op;
    s_axis_tdata <= {6'd0, c.xlsb, c.lsb, c.msb, c.minus, c.plus};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    thermo_sb.note_command(c);
  endtask

  // Stop offering and wait for every owed status transfer.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (!thermo_sb.idle());
  endtask

  // Leaves cfg_we high; the caller drops it after the last write.
  task automatic write_reg(input cfg_idx_t idx, input logic [CAL_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    thermo_sb.write_register(idx, value);
    @(posedge clk);
  endtask

  // Write all registers; only called while the block is idle.
  task automatic load_settings(input settings_t s);
    write_reg(CFG_CAL_T1, CAL_W'(s.t1));
    write_reg(CFG_CAL_T2, CAL_W'(s.t2));
    write_reg(CFG_CAL_T3, CAL_W'(s.t3));
    write_reg(CFG_SETPOINT_MAX, CAL_W'(s.sp_max));
    write_reg(CFG_SETPOINT_MIN, CAL_W'(s.sp_min));
    write_reg(CFG_BLINK_TICKS, CAL_W'(s.blink));
    write_reg(CFG_LOCKOUT_TICKS, CAL_W'(s.lock));
    cfg_we <= 1'b0;
  endtask

  // Random items in bursts with gaps of varied length, so idle cycles fall
  // on every stage of the block's work. Under pressure, wait for the
  // receiver's long hold and then push a long back-to-back burst into it.
  task automatic run_random(input int count, input bit pressure);
    int burst;
    int gap;
    burst = $urandom_range(1, 16);
    if (pressure) begin
      long_hold_req = 1'b1;
      wait (hold_active);
      burst = 48;
    end
    for (int n = 0; n < count; n++) begin
      send_cmd(random_cmd());
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      end
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero calibration, both buttons in one poll, lockout.
    send_cmd(make_cmd(OP_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_NOP, 1'b1, 1'b1, 8'hA5, 8'h5A, 8'hFF));
    send_cmd(make_cmd(OP_SAMPLE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_SAMPLE, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF));
    send_cmd(make_cmd(OP_BUTTON, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_BUTTON, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_BUTTON, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    drain();

    // Both limits on the setpoint, zero blink and lockout counts, and a
    // warm then a cool reading with typical calibration.
    load_settings('{27504, 26435, -1000, 20, 20, 0, 0});
    send_cmd(make_cmd(OP_BUTTON, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_BUTTON, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_BUTTON, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_SAMPLE, 1'b0, 1'b0, 8'h7E, 8'hED, 8'h00));
    send_cmd(make_cmd(OP_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_BUTTON, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_SAMPLE, 1'b0, 1'b0, 8'h75, 8'h30, 8'h00));
    drain();

    // Extreme calibration: saturate low, widest limits, longest counts.
    load_settings('{65535, 32767, -32768, 127, 0, 255, 255});
    send_cmd(make_cmd(OP_SAMPLE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_BUTTON, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    drain();

    // Saturate high; setpoint now above the upper limit.
    load_settings('{0, 32767, 32767, 10, 0, 1, 1});
    send_cmd(make_cmd(OP_SAMPLE, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF));
    send_cmd(make_cmd(OP_BUTTON, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    drain();

    // Most negative calibration words.
    load_settings('{0, -32768, -32768, 30, 15, 3, 2});
    send_cmd(make_cmd(OP_SAMPLE, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hF0));
    send_cmd(make_cmd(OP_BUTTON, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    send_cmd(make_cmd(OP_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
    drain();

    // Random phases, each under fresh settings; one runs into a long stall.
    for (int p = 0; p < RAND_PHASES; p++) begin
      load_settings(random_settings());
      run_random(PHASE_ITEMS, p == 2);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d ticks, %0d button polls, %0d temperature samples, %0d unused opcodes",
             thermo_sb.op_count[OP_TICK], thermo_sb.op_count[OP_BUTTON],
             thermo_sb.op_count[OP_SAMPLE], thermo_sb.op_count[OP_NOP]);
    $display("%0d status transfers checked, %0d presses at a limit, %0d saturated, %0d long holds",
             thermo_sb.checked, thermo_sb.limit_presses, thermo_sb.saturated, long_holds);
    if (thermo_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: thermostat_with_sensor_compensation.f
+incdir+rtl
rtl/tsc_pkg.sv
rtl/tsc_serial_mult.sv
rtl/tsc_compensate.sv
rtl/tsc_buttons.sv
rtl/thermostat_with_sensor_compensation.sv
bench/thermostat_with_sensor_compensation_tb.sv
